### rtl/address_region_interval_map_assert.svh
// ----------------------------------------------------------------------------
// Address region interval map assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_REGION_INTERVAL_MAP_ASSERT_SVH
`define ADDRESS_REGION_INTERVAL_MAP_ASSERT_SVH

// Clocked implication check, disabled during reset.
`define ARIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ARIM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/arim_pkg.sv
// ----------------------------------------------------------------------------
// Address region interval map package
// Shared types and constants of the block and segment extent tables.
// ----------------------------------------------------------------------------
`default_nettype none

package arim_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic KIND_BLOCK   = 1'b0;
  localparam logic KIND_SEGMENT = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD         = 2'd0,
    OP_REMOVE      = 2'd1,
    OP_CLASSIFY    = 2'd2,
    OP_SEG_LOOKUP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CLASS_NONE       = 2'd0,
    CLASS_IN_BLOCK   = 2'd1,
    CLASS_IN_SEGMENT = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e         op;
    logic        kind;
    logic [63:0] address;
    logic [63:0] extent_size;
    logic [7:0]  extent_device;
  } req_t;

  typedef struct packed {
    status_e     status;
    class_e      region_class;
    logic        found;
    logic [63:0] hit_base;
    logic [63:0] hit_size;
    logic [7:0]  hit_device;
  } rsp_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
  } blk_entry_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [7:0]  device;
  } seg_entry_t;

endpackage

`default_nettype wire

### rtl/arim_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/address_region_interval_map.sv
// ----------------------------------------------------------------------------
// Address region interval map
// Block and segment extent tables with add, remove and enclosing lookups.
// ----------------------------------------------------------------------------
// Every word takes one pass over both tables, one entry per cycle from each
// table RAM, so a word accepted with start high and busy low keeps busy high
// through the scan, drain and finish states; its result word appears on
// rsp_o with valid_o high for exactly one cycle as busy falls, and the next
// word can be accepted at the end of that cycle. The receiver must take the
// result in that cycle.
`default_nettype none

module address_region_interval_map (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire arim_pkg::req_t req_i,
  output logic               valid_o,
  output arim_pkg::rsp_t     rsp_o
);

  import arim_pkg::*;

  `include "address_region_interval_map_assert.svh"

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_e state_q, state_d;
  logic   scan_en;

  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic   valid_q;

  logic [IDX_W-1:0] cnt_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic [TABLE_ENTRIES-1:0] blk_vld_q;
  logic [TABLE_ENTRIES-1:0] seg_vld_q;

  blk_entry_t blk_rd;
  seg_entry_t seg_rd;

  logic        blk_best_q;
  logic [63:0] blk_best_base_q;
  logic [63:0] blk_best_size_q;
  logic        seg_best_q;
  logic [63:0] seg_best_base_q;
  logic [63:0] seg_best_size_q;
  logic [7:0]  seg_best_dev_q;

  logic             match_q;
  logic [IDX_W-1:0] match_idx_q;
  logic             free_q;
  logic [IDX_W-1:0] free_idx_q;

  logic             accept;
  logic             ent_blk_vld;
  logic             ent_seg_vld;
  logic             sel_vld;
  logic [63:0]      sel_base;
  logic             blk_cover;
  logic             seg_cover;
  logic             add_ok;
  logic [IDX_W-1:0] wr_idx;
  logic             blk_we;
  logic             seg_we;
  logic             rem_ok;
  blk_entry_t       blk_wr;
  seg_entry_t       seg_wr;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_d = ST_FINISH;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy    = 1'b0;
      ST_SCAN:  scan_en = 1'b1;
      default:  busy    = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_en;
      rd_idx_q <= cnt_q;
      valid_q  <= (state_q == ST_FINISH);
      if (accept) begin
        cnt_q <= '0;
      end else if (scan_en) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_FINISH) begin
      rsp_q <= rsp_d;
    end
  end

  arim_ram #(
    .WIDTH ($bits(blk_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (wr_idx),
    .wdata_i (blk_wr),
    .raddr_i (cnt_q),
    .rdata_o (blk_rd)
  );

  arim_ram #(
    .WIDTH ($bits(seg_entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (wr_idx),
    .wdata_i (seg_wr),
    .raddr_i (cnt_q),
    .rdata_o (seg_rd)
  );

  assign ent_blk_vld = rd_vld_q && blk_vld_q[rd_idx_q];
  assign ent_seg_vld = rd_vld_q && seg_vld_q[rd_idx_q];
  assign sel_vld     = (req_q.kind == KIND_SEGMENT) ? seg_vld_q[rd_idx_q] : blk_vld_q[rd_idx_q];
  assign sel_base    = (req_q.kind == KIND_SEGMENT) ? seg_rd.base : blk_rd.base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_best_q <= 1'b0;
      seg_best_q <= 1'b0;
      match_q    <= 1'b0;
      free_q     <= 1'b0;
    end else if (accept) begin
      blk_best_q <= 1'b0;
      seg_best_q <= 1'b0;
      match_q    <= 1'b0;
      free_q     <= 1'b0;
    end else if (rd_vld_q) begin
      if (ent_blk_vld && blk_rd.base <= req_q.address &&
          (!blk_best_q || blk_rd.base > blk_best_base_q)) begin
        blk_best_q <= 1'b1;
      end
      if (ent_seg_vld && seg_rd.base <= req_q.address &&
          (!seg_best_q || seg_rd.base > seg_best_base_q)) begin
        seg_best_q <= 1'b1;
      end
      if (sel_vld && sel_base == req_q.address) begin
        match_q <= 1'b1;
      end
      if (!sel_vld) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_blk_vld && blk_rd.base <= req_q.address &&
        (!blk_best_q || blk_rd.base > blk_best_base_q)) begin
      blk_best_base_q <= blk_rd.base;
      blk_best_size_q <= blk_rd.size;
    end
    if (ent_seg_vld && seg_rd.base <= req_q.address &&
        (!seg_best_q || seg_rd.base > seg_best_base_q)) begin
      seg_best_base_q <= seg_rd.base;
      seg_best_size_q <= seg_rd.size;
      seg_best_dev_q  <= seg_rd.device;
    end
    if (rd_vld_q && sel_vld && !match_q && sel_base == req_q.address) begin
      match_idx_q <= rd_idx_q;
    end
    if (rd_vld_q && !sel_vld && !free_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  assign blk_cover = blk_best_q && ((req_q.address - blk_best_base_q) < blk_best_size_q);
  assign seg_cover = seg_best_q && ((req_q.address - seg_best_base_q) < seg_best_size_q);

  assign add_ok = (req_q.op == OP_ADD) && (req_q.extent_size != '0) && (match_q || free_q);
  assign rem_ok = (req_q.op == OP_REMOVE) && match_q;
  assign wr_idx = match_q ? match_idx_q : free_idx_q;
  assign blk_we = (state_q == ST_FINISH) && add_ok && (req_q.kind == KIND_BLOCK);
  assign seg_we = (state_q == ST_FINISH) && add_ok && (req_q.kind == KIND_SEGMENT);

  assign blk_wr = '{base: req_q.address, size: req_q.extent_size};
  assign seg_wr = '{base: req_q.address, size: req_q.extent_size,
                    device: req_q.extent_device};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_vld_q <= '0;
      seg_vld_q <= '0;
    end else if (state_q == ST_FINISH) begin
      if (blk_we) begin
        blk_vld_q[wr_idx] <= 1'b1;
      end
      if (seg_we) begin
        seg_vld_q[wr_idx] <= 1'b1;
      end
      if (rem_ok && req_q.kind == KIND_BLOCK) begin
        blk_vld_q[match_idx_q] <= 1'b0;
      end
      if (rem_ok && req_q.kind == KIND_SEGMENT) begin
        seg_vld_q[match_idx_q] <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp_d = '{status: STATUS_DONE, region_class: CLASS_NONE, found: 1'b0,
              hit_base: '0, hit_size: '0, hit_device: '0};
    unique case (req_q.op)
      OP_ADD: begin
        if (req_q.extent_size == '0) begin
          rsp_d.status = STATUS_IGNORED;
        end else if (!match_q && !free_q) begin
          rsp_d.status = STATUS_FULL;
        end
      end
      OP_REMOVE: begin
        rsp_d.status = STATUS_DONE;
      end
      OP_CLASSIFY: begin
        if (blk_cover) begin
          rsp_d.region_class = CLASS_IN_BLOCK;
          rsp_d.hit_base     = blk_best_base_q;
          rsp_d.hit_size     = blk_best_size_q;
        end else if (seg_cover) begin
          rsp_d.region_class = CLASS_IN_SEGMENT;
        end
      end
      OP_SEG_LOOKUP: begin
        if (seg_cover) begin
          rsp_d.found      = 1'b1;
          rsp_d.hit_base   = seg_best_base_q;
          rsp_d.hit_size   = seg_best_size_q;
          rsp_d.hit_device = seg_best_dev_q;
        end
      end
      default: rsp_d.status = STATUS_DONE;
    endcase
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `ARIM_ASSERT(a_result_when_idle, valid_o |-> !busy, "result word shown while busy")
  `ARIM_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `ARIM_ASSERT(a_read_in_scan, rd_vld_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN), "table read data outside the scan")
  `ARIM_ASSERT(a_zero_add_keeps, (state_q == ST_FINISH && req_q.op == OP_ADD && req_q.extent_size == '0) |=> ($stable(blk_vld_q) && $stable(seg_vld_q)), "zero-size add changed a table")

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address region interval map testbench
// Drives add, remove, classify and segment lookup words through the command
// handshake and checks every result word against a shadow copy of the block
// and segment tables kept inside the testbench. A directed opening is
// followed by random phases that fill, mix and drain the tables.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import arim_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic        kind;
    logic [63:0] base;
    logic [63:0] size;
  } extent_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  req_t   req_i = '0;
  logic   valid_o;
  rsp_t   rsp_o;

  req_t    pending_words [$];
  rsp_t    expected_words [$];
  extent_t recent_extents [$];

  logic [63:0] tbl_base [2][TABLE_ENTRIES];
  logic [63:0] tbl_size [2][TABLE_ENTRIES];
  logic        tbl_live [2][TABLE_ENTRIES];
  logic [7:0]  seg_device [TABLE_ENTRIES];

  int   error_count = 0;
  int   accepted_count = 0;
  int   total_words = 0;
  int   cycle_count = 0;
  int   gap_left = 0;
  int   burst_left = 1;
  logic taken = 1'b0;

  address_region_interval_map dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int slot_of_base(input logic kind, input logic [63:0] base);
    int i;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_live[kind][i] && tbl_base[kind][i] == base) return i;
    end
    return -1;
  endfunction

  function automatic int covering_slot(input logic kind, input logic [63:0] addr);
    int i;
    int best;
    best = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_live[kind][i] && tbl_base[kind][i] <= addr &&
          (best < 0 || tbl_base[kind][i] > tbl_base[kind][best])) best = i;
    end
    if (best < 0) return -1;
    if (addr - tbl_base[kind][best] >= tbl_size[kind][best]) return -1;
    return best;
  endfunction

  function automatic rsp_t predict_answer(input req_t w);
    rsp_t a;
    int   slot;
    int   i;
    a = '0;
    case (w.op)
      OP_ADD: begin
        if (w.extent_size == 64'd0) begin
          a.status = STATUS_IGNORED;
        end else begin
          slot = slot_of_base(w.kind, w.address);
          for (i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
            if (!tbl_live[w.kind][i]) slot = i;
          end
          if (slot < 0) begin
            a.status = STATUS_FULL;
          end else begin
            tbl_base[w.kind][slot] = w.address;
            tbl_size[w.kind][slot] = w.extent_size;
            tbl_live[w.kind][slot] = 1'b1;
            if (w.kind == KIND_SEGMENT) seg_device[slot] = w.extent_device;
          end
        end
      end
      OP_REMOVE: begin
        slot = slot_of_base(w.kind, w.address);
        if (slot >= 0) tbl_live[w.kind][slot] = 1'b0;
      end
      OP_CLASSIFY: begin
        slot = covering_slot(KIND_BLOCK, w.address);
        if (slot >= 0) begin
          a.region_class = CLASS_IN_BLOCK;
          a.hit_base = tbl_base[KIND_BLOCK][slot];
          a.hit_size = tbl_size[KIND_BLOCK][slot];
        end else if (covering_slot(KIND_SEGMENT, w.address) >= 0) begin
          a.region_class = CLASS_IN_SEGMENT;
        end
      end
      default: begin
        slot = covering_slot(KIND_SEGMENT, w.address);
        if (slot >= 0) begin
          a.found = 1'b1;
          a.hit_base = tbl_base[KIND_SEGMENT][slot];
          a.hit_size = tbl_size[KIND_SEGMENT][slot];
          a.hit_device = seg_device[slot];
        end
      end
    endcase
    return a;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic push_word(input op_e op, input logic kind, input logic [63:0] addr,
                           input logic [63:0] size, input logic [7:0] dev);
    req_t w;
    w.op = op;
    w.kind = kind;
    w.address = addr;
    w.extent_size = size;
    w.extent_device = dev;
    pending_words.push_back(w);
    if (op == OP_ADD && size != 64'd0) begin
      recent_extents.push_back('{kind: kind, base: addr, size: size});
      if (recent_extents.size() > 128) void'(recent_extents.pop_front());
    end
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !taken) begin
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() > 0) begin
      req_i <= pending_words.pop_front();
      start <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0: gap_left <= 0;
          1: gap_left <= $urandom_range(1, 5);
          2: gap_left <= $urandom_range(1, TABLE_ENTRIES + 4);
          default: gap_left <= 0;
        endcase
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    rsp_t exp_w;
    taken <= rst_ni && start && !busy;
    if (rst_ni) begin
      if (valid_o) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          error_count++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("status", 64'(exp_w.status), 64'(rsp_o.status));
          check_field("region_class", 64'(exp_w.region_class), 64'(rsp_o.region_class));
          check_field("found", 64'(exp_w.found), 64'(rsp_o.found));
          check_field("hit_base", exp_w.hit_base, rsp_o.hit_base);
          check_field("hit_size", exp_w.hit_size, rsp_o.hit_size);
          check_field("hit_device", 64'(exp_w.hit_device), 64'(rsp_o.hit_device));
        end
      end
      if (start && !busy) begin
        expected_words.push_back(predict_answer(req_i));
        accepted_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          n;
    int          mode;
    int          roll;
    int          add_pct;
    int          rem_pct;
    int          cls_pct;
    int          idx;
    logic        bias;
    logic        kind;
    logic [7:0]  dev;
    logic [63:0] addr;
    logic [63:0] size;
    extent_t     pick;

    for (n = 0; n < TABLE_ENTRIES; n++) begin
      tbl_live[0][n] = 1'b0;
      tbl_live[1][n] = 1'b0;
      tbl_base[0][n] = '0;
      tbl_base[1][n] = '0;
      tbl_size[0][n] = '0;
      tbl_size[1][n] = '0;
      seg_device[n] = '0;
    end

    push_word(OP_CLASSIFY, KIND_BLOCK, 64'h0, 64'h0, 8'h00);
    push_word(OP_SEG_LOOKUP, KIND_SEGMENT, '1, '1, 8'hFF);
    push_word(OP_ADD, KIND_BLOCK, 64'h1000, 64'h0, 8'h00);
    push_word(OP_ADD, KIND_BLOCK, 64'h1000, 64'h100, 8'h00);
    push_word(OP_ADD, KIND_BLOCK, 64'h1000, 64'h200, 8'h3C);
    push_word(OP_CLASSIFY, KIND_BLOCK, 64'h11FF, 64'h0, 8'h00);
    push_word(OP_CLASSIFY, KIND_BLOCK, 64'h1200, 64'h0, 8'h00);
    push_word(OP_ADD, KIND_SEGMENT, 64'h800, 64'h2000, 8'hFF);
    push_word(OP_CLASSIFY, KIND_SEGMENT, 64'h1100, 64'h0, 8'h00);
    push_word(OP_CLASSIFY, KIND_BLOCK, 64'h1200, 64'h0, 8'h00);
    push_word(OP_SEG_LOOKUP, KIND_BLOCK, 64'h900, 64'h0, 8'h00);
    push_word(OP_ADD, KIND_SEGMENT, 64'h1800, 64'h10, 8'h5A);
    push_word(OP_SEG_LOOKUP, KIND_SEGMENT, 64'h1900, 64'h0, 8'h00);
    push_word(OP_ADD, KIND_SEGMENT, 64'hFFFF_FFFF_FFFF_FF00, '1, 8'hA5);
    push_word(OP_SEG_LOOKUP, KIND_SEGMENT, '1, 64'h0, 8'h00);
    push_word(OP_SEG_LOOKUP, KIND_SEGMENT, 64'h7FF, 64'h0, 8'h00);
    push_word(OP_REMOVE, KIND_BLOCK, 64'h1000, 64'h0, 8'h00);
    push_word(OP_REMOVE, KIND_BLOCK, 64'h1234, 64'h0, 8'h00);
    push_word(OP_CLASSIFY, KIND_BLOCK, 64'h1000, 64'h0, 8'h00);
    push_word(OP_ADD, KIND_BLOCK, '1, 64'h1, 8'h00);
    push_word(OP_CLASSIFY, KIND_BLOCK, '1, 64'h0, 8'h00);
    push_word(OP_REMOVE, KIND_SEGMENT, 64'h800, 64'h0, 8'h00);
    push_word(OP_SEG_LOOKUP, KIND_SEGMENT, 64'h900, 64'h0, 8'h00);

    // Phases alternate between filling one table, mixed traffic and draining,
    // so both tables reach the full state and empty out again.
    for (phase = 0; phase < 8; phase++) begin
      mode = phase % 4;
      bias = (mode == 0) ? KIND_BLOCK : KIND_SEGMENT;
      case (mode)
        0, 2: begin
          add_pct = 70; rem_pct = 5; cls_pct = 15;
        end
        1: begin
          add_pct = 30; rem_pct = 15; cls_pct = 30;
        end
        default: begin
          add_pct = 10; rem_pct = 45; cls_pct = 25;
        end
      endcase
      for (n = 0; n < 190; n++) begin
        roll = $urandom_range(0, 99);
        dev = 8'($urandom_range(0, 255));
        if ((mode == 0 || mode == 2) && $urandom_range(0, 99) < 85) kind = bias;
        else kind = 1'($urandom_range(0, 1));
        if (roll < add_pct) begin
          case ($urandom_range(0, 9))
            0, 1: addr = rand_word();
            2: begin
              if (recent_extents.size() > 0) begin
                pick = recent_extents[$urandom_range(0, recent_extents.size() - 1)];
                addr = pick.base;
                kind = pick.kind;
              end else begin
                addr = rand_word();
              end
            end
            3, 4: addr = 64'h0 + $urandom_range(0, 'hFFFF);
            5, 6: addr = 64'h0000_0000_4000_0000 + $urandom_range(0, 'hFFFF);
            7: addr = 64'h8000_0000_0000_0000 + $urandom_range(0, 'hFFFF);
            default: addr = 64'hFFFF_FFFF_FFFF_0000 + $urandom_range(0, 'hFFFF);
          endcase
          case ($urandom_range(0, 19))
            0: size = 64'h0;
            1: size = '1;
            2, 3: size = rand_word();
            4, 5: size = 64'h1;
            default: size = 64'($urandom_range(1, 'h1000));
          endcase
          push_word(OP_ADD, kind, addr, size, dev);
        end else if (roll < add_pct + rem_pct) begin
          if (recent_extents.size() > 0 && $urandom_range(0, 9) != 0) begin
            idx = $urandom_range(0, recent_extents.size() - 1);
            pick = recent_extents[idx];
            recent_extents.delete(idx);
            push_word(OP_REMOVE, pick.kind, pick.base, rand_word(), dev);
          end else begin
            push_word(OP_REMOVE, kind, rand_word(), rand_word(), dev);
          end
        end else begin
          if (recent_extents.size() > 0 && $urandom_range(0, 4) != 0) begin
            pick = recent_extents[$urandom_range(0, recent_extents.size() - 1)];
            case ($urandom_range(0, 4))
              0: addr = pick.base;
              1: addr = pick.base + pick.size - 64'd1;
              2: addr = pick.base + pick.size;
              3: addr = pick.base + $urandom_range(0, 'h3FFF);
              default: addr = pick.base - 64'd1;
            endcase
          end else begin
            addr = rand_word();
          end
          push_word((roll < add_pct + rem_pct + cls_pct) ? OP_CLASSIFY : OP_SEG_LOOKUP,
                    kind, addr, rand_word(), dev);
        end
      end
    end
    total_words = pending_words.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (accepted_count < total_words) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/arim_pkg.sv
rtl/arim_ram.sv
rtl/address_region_interval_map.sv
verif/testbench.sv
